// ===== hdl/lmbb_pkg.sv =====
// Shared definitions for the label mask bounding box scan.
// Holds field widths, register indexes, record kinds and the control structs.
// Used by lmbb_ctrl, lmbb_dpath and label_mask_bounding_box_scan.
package lmbb_pkg;

    localparam int LMBB_MAX_AREAS = 16;
    localparam int LMBB_MAX_SIDE  = 4096;

    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int LABEL_W  = 8;
    localparam int INDEX_W  = 12;
    localparam int TOP_W    = 12;
    localparam int BOTTOM_W = 13;
    localparam int COL_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] MASK_WIDTH_RST  = 13'd320;
    localparam logic [CFG_W-1:0] MASK_HEIGHT_RST = 13'd200;

    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the pixel and read its box entry
        logic upd;        // fold the pixel into column and box state
        logic col_load;   // load the column record and advance the scan
        logic dump_rd;    // read the box entry of the current area
        logic dump_load;  // load the box record of the current area
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic col_end;    // current row is the last of its column
        logic frame_end;  // current column is the last of the mask
        logic area_last;  // dump pointer sits on the last area label
    } t_sts;

endpackage

// ===== hdl/lmbb_ctrl.sv =====
// Controller of the label mask bounding box scan.
// Sequences pixel update, column record and box dump; owns the output valid flag.
// Depends on lmbb_pkg.
module lmbb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  lmbb_pkg::t_sts i_sts,
    output lmbb_pkg::t_cmd o_cmd
);
    import lmbb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_DRD  = 3'd3;
    localparam logic [2:0] S_DOUT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = i_sts.col_end ? S_COL : S_IDLE;
            end
            S_COL: begin
                if (out_free) begin
                    cmd.col_load = 1'b1;
                    n_state      = i_sts.frame_end ? S_DRD : S_IDLE;
                end
            end
            S_DRD: begin
                cmd.dump_rd = 1'b1;
                n_state     = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    cmd.dump_load = 1'b1;
                    n_state       = i_sts.area_last ? S_IDLE : S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.col_load || cmd.dump_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    // A record is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.col_load || cmd.dump_load) |-> (!r_out_vld || i_out_ready))
        else $error("record loaded over a pending record");

    // An accepted pixel is folded in on the very next cycle.
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_UPD))
        else $error("accepted pixel not followed by update");

    // The dump ends on the last area and the block is ready again.
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.dump_load && i_sts.area_last) |=> o_in_ready)
        else $error("dump did not return to idle");

    // At most one command is issued in a cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("several commands at once");

endmodule

// ===== hdl/lmbb_dpath.sv =====
// Datapath of the label mask bounding box scan.
// Holds size registers, scan counters, column extent, box memory and record register.
// Depends on lmbb_pkg.
module lmbb_dpath #(
    parameter int MAX_AREAS = lmbb_pkg::LMBB_MAX_AREAS,
    parameter int MAX_SIDE  = lmbb_pkg::LMBB_MAX_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lmbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmbb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [lmbb_pkg::LABEL_W-1:0]    i_mask_label,
    input  lmbb_pkg::t_cmd                  i_cmd,
    output lmbb_pkg::t_sts                  o_sts,
    output logic                            o_record_kind,
    output logic [lmbb_pkg::INDEX_W-1:0]    o_record_index,
    output logic                            o_present,
    output logic [lmbb_pkg::TOP_W-1:0]      o_top_row,
    output logic [lmbb_pkg::BOTTOM_W-1:0]   o_bottom_row,
    output logic [lmbb_pkg::COL_W-1:0]      o_left_col,
    output logic [lmbb_pkg::COL_W-1:0]      o_right_col,
    output logic                            o_none_found,
    output logic                            o_last_record
);
    import lmbb_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int AW = $clog2(MAX_AREAS);
    localparam int MW = 4 * CW;
    localparam logic [AW-1:0] AREA_LAST = AW'(MAX_AREAS - 1);

    // Size registers.
    logic [CFG_W-1:0] r_mask_width, r_mask_height;

    // Scan and column state.
    logic [CW-1:0] r_row, r_col;
    logic          r_cseen;
    logic [CW-1:0] r_ctop;
    logic [CW:0]   r_cbot;
    logic          r_any;
    logic          r_none;

    // Box store.
    logic [MAX_AREAS-1:0] r_bvalid;
    logic [MW-1:0]        r_mem [MAX_AREAS];
    logic [MW-1:0]        r_rd;
    logic [AW-1:0]        r_area;
    logic [LABEL_W-1:0]   r_lab;

    logic [31:0]   w_lim, h_lim;
    logic [CW-1:0] wm1, hm1;
    logic          is_area;
    logic [AW-1:0] lab_addr, rd_addr;
    logic [CW-1:0] b_top, b_bot, b_left, b_right;
    logic [CW-1:0] n_top, n_bot, n_left, n_right;
    logic          frame_none;
    logic [31:0]   col_x, ctop_x, cbot_x, area_x;
    logic [31:0]   top_x, bot_x, left_x, right_x;

    function automatic logic [31:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [31:0] s;
        s = 32'(v);
        if (s == 32'd0) begin
            return 32'd1;
        end else if (s > 32'(MAX_SIDE)) begin
            return 32'(MAX_SIDE);
        end else begin
            return s;
        end
    endfunction

    assign w_lim = clamp_side(r_mask_width)  - 32'd1;
    assign h_lim = clamp_side(r_mask_height) - 32'd1;
    assign wm1   = w_lim[CW-1:0];
    assign hm1   = h_lim[CW-1:0];

    assign o_sts.col_end   = (r_row >= hm1);
    assign o_sts.frame_end = (r_col >= wm1);
    assign o_sts.area_last = (r_area == AREA_LAST);

    assign is_area  = (r_lab != '0) && ({1'b0, r_lab} < 9'(MAX_AREAS));
    assign lab_addr = r_lab[AW-1:0];
    assign rd_addr  = i_cmd.accept ? i_mask_label[AW-1:0] : r_area;

    assign {b_top, b_bot, b_left, b_right} = r_rd;

    // Merge the pixel into the stored box; a fresh label starts a box at this pixel.
    always_comb begin
        if (!r_bvalid[lab_addr]) begin
            n_top   = r_row;
            n_bot   = r_row;
            n_left  = r_col;
            n_right = r_col;
        end else begin
            n_top   = (r_row < b_top)   ? r_row : b_top;
            n_bot   = (r_row > b_bot)   ? r_row : b_bot;
            n_left  = (r_col < b_left)  ? r_col : b_left;
            n_right = (r_col > b_right) ? r_col : b_right;
        end
    end

    assign frame_none = o_sts.frame_end && !r_any;

    assign col_x   = 32'(r_col);
    assign ctop_x  = 32'(r_ctop);
    assign cbot_x  = 32'(r_cbot);
    assign area_x  = 32'(r_area);
    assign top_x   = 32'(b_top);
    assign bot_x   = 32'(b_bot);
    assign left_x  = 32'(b_left);
    assign right_x = 32'(b_right);

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && is_area) begin
            r_mem[lab_addr] <= {n_top, n_bot, n_left, n_right};
        end
        if (i_cmd.accept || i_cmd.dump_rd) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lab <= i_mask_label;
        end
        if (i_cmd.col_load) begin
            o_record_kind  <= KIND_COLUMN;
            o_record_index <= col_x[INDEX_W-1:0];
            o_present      <= r_cseen;
            o_top_row      <= r_cseen ? ctop_x[TOP_W-1:0] : '0;
            o_bottom_row   <= r_cseen ? cbot_x[BOTTOM_W-1:0] : '0;
            o_left_col     <= '0;
            o_right_col    <= '0;
            o_none_found   <= frame_none;
            o_last_record  <= !o_sts.frame_end;
        end else if (i_cmd.dump_load) begin
            o_record_kind  <= KIND_BOX;
            o_record_index <= area_x[INDEX_W-1:0];
            o_present      <= r_bvalid[r_area];
            o_top_row      <= r_bvalid[r_area] ? top_x[TOP_W-1:0] : '0;
            o_bottom_row   <= r_bvalid[r_area] ? bot_x[BOTTOM_W-1:0] : '0;
            o_left_col     <= r_bvalid[r_area] ? left_x[COL_W-1:0] : '0;
            o_right_col    <= r_bvalid[r_area] ? right_x[COL_W-1:0] : '0;
            o_none_found   <= r_none;
            o_last_record  <= o_sts.area_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_width  <= MASK_WIDTH_RST;
            r_mask_height <= MASK_HEIGHT_RST;
            r_row         <= '0;
            r_col         <= '0;
            r_cseen       <= 1'b0;
            r_ctop        <= '0;
            r_cbot        <= '0;
            r_any         <= 1'b0;
            r_none        <= 1'b0;
            r_bvalid      <= '0;
            r_area        <= AW'(1);
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_MASK_WIDTH)) begin
                r_mask_width <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == REG_MASK_HEIGHT)) begin
                r_mask_height <= i_cfg_data;
            end
            if (i_cmd.upd) begin
                if (is_area) begin
                    if (!r_cseen) begin
                        r_ctop  <= r_row;
                        r_cseen <= 1'b1;
                        r_any   <= 1'b1;
                    end
                    r_cbot             <= {1'b0, r_row} + 1'b1;
                    r_bvalid[lab_addr] <= 1'b1;
                end
                if (!o_sts.col_end) begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (i_cmd.col_load) begin
                r_row   <= '0;
                r_cseen <= 1'b0;
                r_ctop  <= '0;
                r_cbot  <= '0;
                r_none  <= frame_none;
                r_col   <= o_sts.frame_end ? '0 : r_col + 1'b1;
            end
            if (i_cmd.dump_load) begin
                if (o_sts.area_last) begin
                    r_area   <= AW'(1);
                    r_bvalid <= '0;
                    r_any    <= 1'b0;
                end else begin
                    r_area <= r_area + 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/label_mask_bounding_box_scan.sv =====
// Label mask bounding box scan, top level: controller plus datapath.
// A pixel that does not end a column is latched, then folded in; ready returns after the update.
// A column end then loads the column record once the output register is free.
// A mask end then dumps MAX_AREAS-1 box records, each read from the box memory, then loaded.
// Synchronous active-low reset clears counters, column state and box valid bits, and restores
// the size registers to 320 columns by 200 rows.
// The box memory itself is not cleared; an entry without its valid bit reads as zero.
module label_mask_bounding_box_scan #(
    parameter int MAX_AREAS = lmbb_pkg::LMBB_MAX_AREAS,
    parameter int MAX_SIDE  = lmbb_pkg::LMBB_MAX_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lmbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmbb_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lmbb_pkg::LABEL_W-1:0]    i_mask_label,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_record_kind,
    output logic [lmbb_pkg::INDEX_W-1:0]    o_record_index,
    output logic                            o_present,
    output logic [lmbb_pkg::TOP_W-1:0]      o_top_row,
    output logic [lmbb_pkg::BOTTOM_W-1:0]   o_bottom_row,
    output logic [lmbb_pkg::COL_W-1:0]      o_left_col,
    output logic [lmbb_pkg::COL_W-1:0]      o_right_col,
    output logic                            o_none_found,
    output logic                            o_last_record
);
    import lmbb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lmbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lmbb_dpath #(
        .MAX_AREAS (MAX_AREAS),
        .MAX_SIDE  (MAX_SIDE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mask_label   (i_mask_label),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_record_kind  (o_record_kind),
        .o_record_index (o_record_index),
        .o_present      (o_present),
        .o_top_row      (o_top_row),
        .o_bottom_row   (o_bottom_row),
        .o_left_col     (o_left_col),
        .o_right_col    (o_right_col),
        .o_none_found   (o_none_found),
        .o_last_record  (o_last_record)
    );

endmodule
